// ===== rtl/lsre_pkg.sv =====
// shared types and constants of the level set reinitialization engine
`default_nettype none
package lsre_pkg;

   // item function codes carried in req_tuser
   typedef enum logic [1:0] {
      FUNC_WRITE = 2'd0,
      FUNC_RUN   = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   // register indexes of the csr port
   typedef enum logic [2:0] {
      CSR_ITER_COUNT = 3'd0,
      CSR_PSEUDO_DT  = 3'd1,
      CSR_INV_X      = 3'd2,
      CSR_INV_Y      = 3'd3,
      CSR_INV_Z      = 3'd4,
      CSR_MIN_SP_SQ  = 3'd5
   } csr_index_type;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 31;
   localparam int ITER_W     = 10;
   localparam int COORD_W    = 4;
   localparam int VALUE_W    = 32;
   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 1;

   localparam logic [ITER_W-1:0]     ITER_RESET  = 10'd20;
   localparam logic [CSR_DATA_W-1:0] DT_RESET    = 31'd32768;
   localparam logic [CSR_DATA_W-1:0] ONE_Q16_31  = 31'd65536;
   localparam logic [CSR_DATA_W-1:0] SAT_DERIV   = 31'h7FFF_FFFF;

endpackage
`default_nettype wire

// ===== rtl/lsre_ram.sv =====
// generic simple dual port ram with registered read
`default_nettype none
module lsre_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end
endmodule
`default_nettype wire

// ===== rtl/level_set_reinit_engine.sv =====
// top level of the level set reinitialization engine
//
// channel | dir | handshake             | contents
// req     | in  | req_tvalid/req_tready | tuser func, tdata cell x,y,z and value
// rsp     | out | rsp_tvalid/rsp_tready | tuser is_read_data, tdata cell value
// csr     | in  | csr_we                | csr_addr register index, csr_wdata value
//
// write item: written to the current bank when accepted. read item: read when accepted, then
// loaded into the output register once it is free. run item: iteration_count sweeps over all
// cells; each cell does 7 single port reads of the current bank, up to two square roots and
// a divide on the shared units. banks swap at the end of an iteration.
// reset clears control state and sets the configuration defaults; the grid banks hold nothing until written.
// a finished result waits in the output register while later items go on.
`default_nettype none
module level_set_reinit_engine #(
   parameter int GRID_X = 16,
   parameter int GRID_Y = 16,
   parameter int GRID_Z = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // cell_x[3:0], cell_y[7:4], cell_z[11:8], write_value[43:12], zero pad
   input  wire logic [lsre_pkg::REQ_DATA_W-1:0]    req_tdata,
   // func[1:0]
   input  wire logic [lsre_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // cell_value[31:0]
   output logic      [lsre_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // is_read_data[0]
   output logic      [lsre_pkg::RSP_USER_W-1:0]    rsp_tuser,
   input  wire logic                               csr_we,
   input  wire logic [lsre_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [lsre_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
   localparam int AW    = $clog2(CELLS);
   localparam int XW    = $clog2(GRID_X);
   localparam int YW    = $clog2(GRID_Y);
   localparam int ZW    = $clog2(GRID_Z);
   localparam logic [AW-1:0] STRIDE_Y  = AW'(GRID_X);
   localparam logic [AW-1:0] STRIDE_Z  = AW'(GRID_X * GRID_Y);
   localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
   localparam logic [XW-1:0] X_LAST    = XW'(GRID_X - 1);
   localparam logic [YW-1:0] Y_LAST    = YW'(GRID_Y - 1);
   localparam logic [ZW-1:0] Z_LAST    = ZW'(GRID_Z - 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD_OUT, ST_FETCH, ST_SQ, ST_SQ_ADD, ST_SQRT, ST_DIV,
      ST_DER_MUL, ST_DER_SQ, ST_DER_ACC, ST_STEP_A, ST_STEP_T, ST_STEP_RES,
      ST_WRITE, ST_FINISH
   } state_type;

   // configuration registers
   logic [lsre_pkg::ITER_W-1:0]     iter_count_ff;
   logic [lsre_pkg::CSR_DATA_W-1:0] dt_ff, inv_x_ff, inv_y_ff, inv_z_ff, mss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_count_ff <= lsre_pkg::ITER_RESET;
         dt_ff         <= lsre_pkg::DT_RESET;
         inv_x_ff      <= lsre_pkg::ONE_Q16_31;
         inv_y_ff      <= lsre_pkg::ONE_Q16_31;
         inv_z_ff      <= lsre_pkg::ONE_Q16_31;
         mss_ff        <= lsre_pkg::ONE_Q16_31;
      end else if (csr_we) begin
         case (lsre_pkg::csr_index_type'(csr_addr))
            lsre_pkg::CSR_ITER_COUNT: iter_count_ff <= csr_wdata[lsre_pkg::ITER_W-1:0];
            lsre_pkg::CSR_PSEUDO_DT:  dt_ff    <= csr_wdata;
            lsre_pkg::CSR_INV_X:      inv_x_ff <= csr_wdata;
            lsre_pkg::CSR_INV_Y:      inv_y_ff <= csr_wdata;
            lsre_pkg::CSR_INV_Z:      inv_z_ff <= csr_wdata;
            lsre_pkg::CSR_MIN_SP_SQ:  mss_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // control and datapath registers
   state_type         state_ff;
   logic              cur_ff;
   logic [lsre_pkg::ITER_W-1:0] iter_ff;
   logic [AW-1:0]     addr_ff;
   logic [XW-1:0]     x_ff;
   logic [YW-1:0]     y_ff;
   logic [ZW-1:0]     z_ff;
   logic [2:0]        k_ff;
   logic [2:0]        j_ff;
   logic [5:0]        div_cnt_ff;
   logic              sqrt_for_g_ff;
   logic              rd_inside_ff;
   logic [31:0]       nb_ff [7];
   logic              positive_ff;
   logic              keep_ff;
   logic              g_pos_ff;
   logic [63:0]       sq_rem_ff, sq_res_ff, sq_bit_ff;
   logic [47:0]       num_ff, quo_ff;
   logic [32:0]       div_rem_ff;
   logic [63:0]       acc_ff;
   logic [31:0]       new_ff;
   logic [65:0]       prod_ff;
   logic              rsp_valid_ff;
   logic [31:0]       rsp_data_ff;
   logic              rsp_user_ff;

   // request decode
   logic [lsre_pkg::COORD_W-1:0] rx, ry, rz;
   logic [31:0]       req_value;
   logic [AW-1:0]     req_addr;
   logic              req_inside, accept;
   lsre_pkg::func_type req_func;

   assign rx        = req_tdata[3:0];
   assign ry        = req_tdata[7:4];
   assign rz        = req_tdata[11:8];
   assign req_value = req_tdata[43:12];
   assign req_func  = lsre_pkg::func_type'(req_tuser);
   assign req_inside = (32'(rx) < GRID_X) && (32'(ry) < GRID_Y) && (32'(rz) < GRID_Z);
   assign req_addr  = AW'(32'(rx) + GRID_X * (32'(ry) + GRID_Y * 32'(rz)));
   assign req_tready = (state_ff == ST_IDLE);
   assign accept    = req_tvalid && req_tready;

   // output slot is free when empty or being taken
   logic slot_free;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // neighbor address for the fetch step, edges clamp to the cell itself
   logic [AW-1:0] fetch_addr;
   always_comb begin
      case (k_ff)
         3'd1:    fetch_addr = (x_ff == '0)     ? addr_ff : addr_ff - AW'(1);
         3'd2:    fetch_addr = (x_ff == X_LAST) ? addr_ff : addr_ff + AW'(1);
         3'd3:    fetch_addr = (y_ff == '0)     ? addr_ff : addr_ff - STRIDE_Y;
         3'd4:    fetch_addr = (y_ff == Y_LAST) ? addr_ff : addr_ff + STRIDE_Y;
         3'd5:    fetch_addr = (z_ff == '0)     ? addr_ff : addr_ff - STRIDE_Z;
         3'd6:    fetch_addr = (z_ff == Z_LAST) ? addr_ff : addr_ff + STRIDE_Z;
         default: fetch_addr = addr_ff;
      endcase
   end

   // memory port control: both banks share one read and one write address
   logic          wr_en, wr_bank, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0]   wr_data, rd_data0, rd_data1, rd_data;

   always_comb begin
      wr_en   = 1'b0;
      wr_bank = cur_ff;
      wr_addr = req_addr;
      wr_data = req_value;
      rd_en   = 1'b0;
      rd_addr = fetch_addr;
      if (state_ff == ST_IDLE && accept) begin
         wr_en   = (req_func == lsre_pkg::FUNC_WRITE) && req_inside;
         rd_en   = (req_func == lsre_pkg::FUNC_READ);
         rd_addr = req_addr;
      end else if (state_ff == ST_FETCH) begin
         rd_en = (k_ff != 3'd7);
      end else if (state_ff == ST_WRITE) begin
         wr_en   = 1'b1;
         wr_bank = !cur_ff;
         wr_addr = addr_ff;
         wr_data = new_ff;
      end
   end

   lsre_ram #(.WIDTH(32), .DEPTH(CELLS)) u_bank0 (
      .clock(clock), .we(wr_en && !wr_bank), .waddr(wr_addr), .wdata(wr_data),
      .re(rd_en), .raddr(rd_addr), .rdata(rd_data0)
   );
   lsre_ram #(.WIDTH(32), .DEPTH(CELLS)) u_bank1 (
      .clock(clock), .we(wr_en && wr_bank), .waddr(wr_addr), .wdata(wr_data),
      .re(rd_en), .raddr(rd_addr), .rdata(rd_data1)
   );
   assign rd_data = cur_ff ? rd_data1 : rd_data0;

   // cell value and its magnitude
   logic [31:0] phi, mp;
   logic [32:0] phi_neg;
   assign phi     = nb_ff[0];
   assign phi_neg = 33'd0 - {phi[31], phi};
   assign mp      = phi[31] ? phi_neg[31:0] : phi;

   // one-sided difference for the current derivative
   logic [31:0]        nbv;
   logic signed [32:0] diff;
   logic [32:0]        diff_mag;
   logic               diff_pos, diff_neg, fwd;
   logic [30:0]        inv_sel;
   assign nbv      = nb_ff[j_ff + 3'd1];
   assign fwd      = j_ff[0];
   assign diff     = fwd ? ($signed({nbv[31], nbv}) - $signed({phi[31], phi}))
                         : ($signed({phi[31], phi}) - $signed({nbv[31], nbv}));
   assign diff_neg = diff[32];
   assign diff_pos = !diff[32] && (diff != '0);
   assign diff_mag = diff_neg ? 33'(-diff) : 33'(diff);
   always_comb begin
      case (j_ff[2:1])
         2'd0:    inv_sel = inv_x_ff;
         2'd1:    inv_sel = inv_y_ff;
         default: inv_sel = inv_z_ff;
      endcase
   end

   // derivative magnitude saturated to 31 bits
   logic [30:0] deriv_m;
   assign deriv_m = (|prod_ff[65:47]) ? lsre_pkg::SAT_DERIV : prod_ff[46:16];

   // gradient minus one
   logic signed [33:0] g1;
   logic [32:0]        g_mag;
   assign g1    = $signed({2'b00, sq_res_ff[31:0]}) - 34'sd65536;
   assign g_mag = g1[33] ? 33'(-g1) : 33'(g1);

   // final step with saturation
   logic signed [49:0] phi_w, res_w;
   logic [31:0]        res_sat;
   assign phi_w = 50'($signed(phi));
   assign res_w = (positive_ff == g_pos_ff) ? phi_w - $signed({1'b0, prod_ff[64:16]})
                                            : phi_w + $signed({1'b0, prod_ff[64:16]});
   always_comb begin
      if (!res_w[49] && (|res_w[48:31])) begin
         res_sat = 32'h7FFF_FFFF;
      end else if (res_w[49] && !(&res_w[48:31])) begin
         res_sat = 32'h8000_0000;
      end else begin
         res_sat = res_w[31:0];
      end
   end

   // shared multiplier operands
   logic [32:0] mul_a, mul_b;
   always_comb begin
      case (state_ff)
         ST_SQ: begin
            mul_a = {1'b0, mp};
            mul_b = {1'b0, mp};
         end
         ST_DER_MUL: begin
            mul_a = diff_mag;
            mul_b = {2'b00, inv_sel};
         end
         ST_DER_SQ: begin
            mul_a = keep_ff ? {2'b00, deriv_m} : '0;
            mul_b = keep_ff ? {2'b00, deriv_m} : '0;
         end
         ST_STEP_A: begin
            mul_a = {2'b00, dt_ff};
            mul_b = {16'd0, quo_ff[16:0]};
         end
         ST_STEP_T: begin
            mul_a = prod_ff[48:16];
            mul_b = g_mag;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // square root step
   logic [63:0] sq_trial;
   logic        sq_take;
   assign sq_trial = sq_res_ff + sq_bit_ff;
   assign sq_take  = sq_rem_ff >= sq_trial;

   // divide step
   logic [32:0] div_shift, div_rem_in;
   logic [47:0] quo_in;
   logic        div_take;
   assign div_shift  = {div_rem_ff[31:0], num_ff[47]};
   assign div_take   = div_shift >= {1'b0, sq_res_ff[31:0]};
   assign div_rem_in = div_take ? div_shift - {1'b0, sq_res_ff[31:0]} : div_shift;
   assign quo_in     = {quo_ff[46:0], div_take};

   // saturating gradient accumulate
   logic [64:0] acc_sum;
   assign acc_sum = {1'b0, acc_ff} + {1'b0, prod_ff[63:0]};

   // sequencer
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (reset) begin
         state_ff      <= ST_IDLE;
         cur_ff        <= 1'b0;
         iter_ff       <= '0;
         addr_ff       <= '0;
         x_ff          <= '0;
         y_ff          <= '0;
         z_ff          <= '0;
         k_ff          <= '0;
         j_ff          <= '0;
         div_cnt_ff    <= '0;
         sqrt_for_g_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // the states that load the output slot handle its release themselves
         if (rsp_valid_ff && rsp_tready && !(state_ff inside {ST_RD_OUT, ST_FINISH})) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  rd_inside_ff <= req_inside;
                  case (req_func)
                     lsre_pkg::FUNC_READ: state_ff <= ST_RD_OUT;
                     lsre_pkg::FUNC_RUN: begin
                        iter_ff <= '0;
                        addr_ff <= '0;
                        x_ff    <= '0;
                        y_ff    <= '0;
                        z_ff    <= '0;
                        k_ff    <= '0;
                        state_ff <= (iter_count_ff == '0) ? ST_FINISH : ST_FETCH;
                     end
                     default: ;
                  endcase
               end
            end
            ST_RD_OUT: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= rd_inside_ff ? rd_data : '0;
                  rsp_user_ff  <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_FETCH: begin
               if (k_ff != 3'd0) begin
                  nb_ff[k_ff - 3'd1] <= rd_data;
               end
               if (k_ff == 3'd7) begin
                  k_ff     <= '0;
                  state_ff <= ST_SQ;
               end else begin
                  k_ff <= k_ff + 3'd1;
               end
            end
            ST_SQ: begin
               positive_ff <= !phi[31] && (phi != '0);
               state_ff    <= ST_SQ_ADD;
            end
            ST_SQ_ADD: begin
               sq_rem_ff     <= prod_ff[63:0] + {17'd0, mss_ff, 16'd0};
               sq_res_ff     <= '0;
               sq_bit_ff     <= 64'd1 << 62;
               sqrt_for_g_ff <= 1'b0;
               state_ff      <= ST_SQRT;
            end
            ST_SQRT: begin
               if (sq_bit_ff != '0) begin
                  if (sq_take) begin
                     sq_rem_ff <= sq_rem_ff - sq_trial;
                     sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
                  end else begin
                     sq_res_ff <= sq_res_ff >> 1;
                  end
                  sq_bit_ff <= sq_bit_ff >> 2;
               end else if (sqrt_for_g_ff) begin
                  state_ff <= ST_STEP_A;
               end else if (sq_res_ff == '0) begin
                  new_ff   <= phi;
                  state_ff <= ST_WRITE;
               end else begin
                  num_ff     <= {mp, 16'd0};
                  quo_ff     <= '0;
                  div_rem_ff <= '0;
                  div_cnt_ff <= '0;
                  state_ff   <= ST_DIV;
               end
            end
            ST_DIV: begin
               div_rem_ff <= div_rem_in;
               quo_ff     <= quo_in;
               num_ff     <= {num_ff[46:0], 1'b0};
               div_cnt_ff <= div_cnt_ff + 6'd1;
               if (div_cnt_ff == 6'd47) begin
                  if (quo_in == '0) begin
                     new_ff   <= phi;
                     state_ff <= ST_WRITE;
                  end else begin
                     j_ff     <= '0;
                     acc_ff   <= '0;
                     state_ff <= ST_DER_MUL;
                  end
               end
            end
            ST_DER_MUL: begin
               keep_ff  <= fwd ? (positive_ff ? diff_neg : diff_pos)
                               : (positive_ff ? diff_pos : diff_neg);
               state_ff <= ST_DER_SQ;
            end
            ST_DER_SQ: begin
               state_ff <= ST_DER_ACC;
            end
            ST_DER_ACC: begin
               acc_ff <= acc_sum[64] ? '1 : acc_sum[63:0];
               if (j_ff == 3'd5) begin
                  sq_rem_ff     <= acc_sum[64] ? '1 : acc_sum[63:0];
                  sq_res_ff     <= '0;
                  sq_bit_ff     <= 64'd1 << 62;
                  sqrt_for_g_ff <= 1'b1;
                  state_ff      <= ST_SQRT;
               end else begin
                  j_ff     <= j_ff + 3'd1;
                  state_ff <= ST_DER_MUL;
               end
            end
            ST_STEP_A: begin
               g_pos_ff <= !g1[33] && (g1 != '0);
               state_ff <= ST_STEP_T;
            end
            ST_STEP_T: begin
               state_ff <= ST_STEP_RES;
            end
            ST_STEP_RES: begin
               new_ff   <= res_sat;
               state_ff <= ST_WRITE;
            end
            ST_WRITE: begin
               if (addr_ff == LAST_CELL) begin
                  cur_ff  <= !cur_ff;
                  addr_ff <= '0;
                  x_ff    <= '0;
                  y_ff    <= '0;
                  z_ff    <= '0;
                  if ({1'b0, iter_ff} + 11'd1 == {1'b0, iter_count_ff}) begin
                     iter_ff  <= '0;
                     state_ff <= ST_FINISH;
                  end else begin
                     iter_ff  <= iter_ff + 10'd1;
                     state_ff <= ST_FETCH;
                  end
               end else begin
                  addr_ff <= addr_ff + AW'(1);
                  if (x_ff == X_LAST) begin
                     x_ff <= '0;
                     if (y_ff == Y_LAST) begin
                        y_ff <= '0;
                        z_ff <= z_ff + ZW'(1);
                     end else begin
                        y_ff <= y_ff + YW'(1);
                     end
                  end else begin
                     x_ff <= x_ff + XW'(1);
                  end
                  state_ff <= ST_FETCH;
               end
            end
            ST_FINISH: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= '0;
                  rsp_user_ff  <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== rtl/lsre_checker.sv =====
// port level checks of the level set reinitialization engine and their binding
`default_nettype none
module lsre_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [lsre_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input wire logic [lsre_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   // a stalled result item stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp item dropped while stalled");

   // a stalled result item keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

   // run completion carries zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("run completion item not zero");

   // no result item in the first cycle after reset
   assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("rsp item offered after reset");
endmodule

bind level_set_reinit_engine lsre_checker u_lsre_checker (.*);
`default_nettype wire

// ===== bench/tb_level_set_reinit_engine.sv =====
// self-checking testbench of the level set reinitialization engine
`default_nettype none
module tb_level_set_reinit_engine;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NX = 16, NY = 16, NZ = 16;
   localparam int NCELLS = NX * NY * NZ;
   localparam logic [lsre_pkg::CSR_ADDR_W-1:0] CSR_UNUSED = 3'd7;
   localparam longint ONE_Q16 = 65536;

   typedef struct {
      lsre_pkg::func_type func;
      logic [3:0]   x, y, z;
      logic [31:0]  value;
   } cell_item_type;

   typedef struct {
      logic [31:0] value;
      logic        is_read;
   } cell_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [lsre_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [lsre_pkg::REQ_USER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [lsre_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [lsre_pkg::RSP_USER_W-1:0] rsp_tuser;
   logic csr_we = 1'b0;
   logic [lsre_pkg::CSR_ADDR_W-1:0] csr_addr = '0;
   logic [lsre_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   level_set_reinit_engine #(.GRID_X(NX), .GRID_Y(NY), .GRID_Z(NZ)) u_top (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_we, .csr_addr, .csr_wdata
   );

   always #5 clock = ~clock;

   // predictor state
   logic [31:0] grid_now [NCELLS];
   logic [31:0] grid_next [NCELLS];
   bit          cell_written [NCELLS];
   logic [9:0]  p_iters;
   logic [30:0] p_dt, p_inv_x, p_inv_y, p_inv_z, p_min_sq;

   cell_item_type   pending_items [$];
   cell_result_type expected_cells [$];
   int  errors = 0;
   bit  req_fire = 1'b0;
   bit  quiet = 1'b0;
   bit  long_hold_go = 1'b0;

   function automatic int cell_index(int x, int y, int z);
      return x + NX * (y + NY * z);
   endfunction

   function automatic longint unsigned mag64(longint v);
      return v < 0 ? longint'(0) - v : v;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
      longint unsigned s;
      s = a + b;
      return s < a ? 64'hFFFF_FFFF_FFFF_FFFF : s;
   endfunction

   function automatic longint slope(longint diff, longint unsigned inv);
      longint unsigned m;
      m = (mag64(diff) * inv) >> 16;
      if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
      return diff < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint unsigned upwind_energy(longint bk, longint fw, bit pos);
      longint b, f;
      if (pos) begin
         b = bk > 0 ? bk : 0;
         f = fw < 0 ? fw : 0;
      end else begin
         b = bk < 0 ? bk : 0;
         f = fw > 0 ? fw : 0;
      end
      return sat_sum(mag64(b) * mag64(b), mag64(f) * mag64(f));
   endfunction

   function automatic longint phi_at(int x, int y, int z);
      return longint'($signed(grid_now[cell_index(x, y, z)]));
   endfunction

   // one godunov upwind update of a cell from the current grid
   function automatic logic [31:0] relaxed_cell(int x, int y, int z);
      longint phi, g1, res;
      longint unsigned mp, d, s, sum, a, t;
      bit pos;
      int xm, xp, ym, yp, zm, zp;
      phi = phi_at(x, y, z);
      mp = mag64(phi);
      d = int_sqrt(mp * mp + (longint'(p_min_sq) << 16));
      if (d == 0) return grid_now[cell_index(x, y, z)];
      s = (mp << 16) / d;
      if (s == 0) return grid_now[cell_index(x, y, z)];
      pos = phi > 0;
      xm = x ? x - 1 : 0; xp = x + 1 < NX ? x + 1 : x;
      ym = y ? y - 1 : 0; yp = y + 1 < NY ? y + 1 : y;
      zm = z ? z - 1 : 0; zp = z + 1 < NZ ? z + 1 : z;
      sum = upwind_energy(slope(phi - phi_at(xm, y, z), p_inv_x),
                          slope(phi_at(xp, y, z) - phi, p_inv_x), pos);
      sum = sat_sum(sum, upwind_energy(slope(phi - phi_at(x, ym, z), p_inv_y),
                                       slope(phi_at(x, yp, z) - phi, p_inv_y), pos));
      sum = sat_sum(sum, upwind_energy(slope(phi - phi_at(x, y, zm), p_inv_z),
                                       slope(phi_at(x, y, zp) - phi, p_inv_z), pos));
      g1 = longint'(int_sqrt(sum)) - ONE_Q16;
      a = (longint'(p_dt) * s) >> 16;
      t = (a * mag64(g1)) >> 16;
      if (pos == (g1 > 0)) res = phi - longint'(t);
      else res = phi + longint'(t);
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      return res[31:0];
   endfunction

   // monitor: config, accepted items, results
   always @(posedge clock) begin
      cell_item_type it;
      cell_result_type got, want;
      req_fire = req_tvalid && req_tready && !reset;
      if (!reset && csr_we) begin
         case (csr_addr)
            lsre_pkg::CSR_ITER_COUNT: p_iters  = csr_wdata[9:0];
            lsre_pkg::CSR_PSEUDO_DT:  p_dt     = csr_wdata;
            lsre_pkg::CSR_INV_X:      p_inv_x  = csr_wdata;
            lsre_pkg::CSR_INV_Y:      p_inv_y  = csr_wdata;
            lsre_pkg::CSR_INV_Z:      p_inv_z  = csr_wdata;
            lsre_pkg::CSR_MIN_SP_SQ:  p_min_sq = csr_wdata;
            default: ;
         endcase
      end
      if (req_fire) begin
         it.func = lsre_pkg::func_type'(req_tuser);
         it.x = req_tdata[3:0];
         it.y = req_tdata[7:4];
         it.z = req_tdata[11:8];
         it.value = req_tdata[43:12];
         case (it.func)
            lsre_pkg::FUNC_WRITE: grid_now[cell_index(it.x, it.y, it.z)] = it.value;
            lsre_pkg::FUNC_READ:
               expected_cells.push_back('{grid_now[cell_index(it.x, it.y, it.z)], 1'b1});
            lsre_pkg::FUNC_RUN: begin
               for (int n = 0; n < p_iters; n++) begin
                  for (int c = 0; c < NCELLS; c++)
                     grid_next[c] = relaxed_cell(c % NX, (c / NX) % NY, c / (NX * NY));
                  grid_now = grid_next;
               end
               expected_cells.push_back('{32'd0, 1'b0});
            end
            default: ;
         endcase
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.value = rsp_tdata;
         got.is_read = rsp_tuser[0];
         if (expected_cells.size() == 0) begin
            errors++;
            $display("%0t unexpected result: actual value %h read %b", $time, got.value,
                     got.is_read);
         end else begin
            want = expected_cells.pop_front();
            if (got.value !== want.value || got.is_read !== want.is_read) begin
               errors++;
               $display("%0t mismatch: expected value %h read %b, actual value %h read %b",
                        $time, want.value, want.is_read, got.value, got.is_read);
            end
         end
      end
   end

   // driver of the item channel
   int send_idle = 0;
   always @(negedge clock) begin
      cell_item_type it;
      if (!reset && (!req_tvalid || req_fire)) begin
         if (send_idle > 0) begin
            send_idle--;
            req_tvalid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            send_idle = $urandom_range(1, 4) - 1;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            it = pending_items.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= it.func;
            req_tdata <= {4'd0, it.value, it.z, it.y, it.x};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver ready with random stalls and one long hold-off
   int recv_idle = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold_go && !hold_done) begin
         hold_done = 1'b1;
         hold_left = 400;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (recv_idle > 0) begin
         recv_idle--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         recv_idle = $urandom_range(1, 4) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic push_item(lsre_pkg::func_type f, int x, int y, int z, logic [31:0] v);
      cell_item_type it;
      it.func = f; it.x = 4'(x); it.y = 4'(y); it.z = 4'(z); it.value = v;
      if (f == lsre_pkg::FUNC_WRITE) cell_written[cell_index(x, y, z)] = 1'b1;
      pending_items.push_back(it);
   endtask

   // read of a random cell that has been written
   task automatic push_read();
      int c;
      do c = $urandom_range(0, NCELLS - 1); while (!cell_written[c]);
      push_item(lsre_pkg::FUNC_READ, c % NX, (c / NX) % NY, c / (NX * NY), $urandom);
   endtask

   task automatic drain();
      do begin
         @(negedge clock);
         #1;
      end while (pending_items.size() != 0 || req_tvalid || expected_cells.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(logic [lsre_pkg::CSR_ADDR_W-1:0] idx,
                            logic [lsre_pkg::CSR_DATA_W-1:0] v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // mostly small distances with occasional extremes
   function automatic logic [31:0] some_distance();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 20 * 65536)) - 10 * 65536);
      endcase
   endfunction

   task automatic random_mix(int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 45) push_item(lsre_pkg::FUNC_WRITE, $urandom_range(0, 15),
                               $urandom_range(0, 15), $urandom_range(0, 15), some_distance());
         else if (r < 88) push_read();
         else if (r < 94) push_item(lsre_pkg::FUNC_RUN, $urandom_range(0, 15),
                                    $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
         else push_item(lsre_pkg::FUNC_NONE, $urandom_range(0, 15), $urandom_range(0, 15),
                        $urandom_range(0, 15), $urandom);
      end
   endtask

   initial begin
      p_iters = lsre_pkg::ITER_RESET; p_dt = lsre_pkg::DT_RESET;
      p_inv_x = lsre_pkg::ONE_Q16_31; p_inv_y = lsre_pkg::ONE_Q16_31;
      p_inv_z = lsre_pkg::ONE_Q16_31;
      p_min_sq = lsre_pkg::ONE_Q16_31;
      for (int c = 0; c < NCELLS; c++) begin
         grid_now[c] = '0;
         cell_written[c] = 1'b0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // runs touch only the grid once all of it is written
      csr_write(lsre_pkg::CSR_ITER_COUNT, 31'd0);

      // directed: corners, extremes, every function, empty run
      push_item(lsre_pkg::FUNC_WRITE, 0, 0, 0, 32'h8000_0000);
      push_item(lsre_pkg::FUNC_WRITE, 15, 15, 15, 32'h7FFF_FFFF);
      push_item(lsre_pkg::FUNC_WRITE, 15, 0, 15, 32'h0000_0000);
      push_item(lsre_pkg::FUNC_WRITE, 0, 15, 0, 32'hFFFF_FFFF);
      push_item(lsre_pkg::FUNC_READ, 0, 0, 0, 32'hFFFF_FFFF);
      push_item(lsre_pkg::FUNC_READ, 15, 15, 15, 32'h0);
      push_item(lsre_pkg::FUNC_READ, 15, 0, 15, 32'h0);
      push_item(lsre_pkg::FUNC_READ, 0, 15, 0, 32'h0);
      push_item(lsre_pkg::FUNC_NONE, 15, 15, 15, 32'hFFFF_FFFF);
      push_item(lsre_pkg::FUNC_RUN, 0, 0, 0, 32'h0);
      push_item(lsre_pkg::FUNC_READ, 0, 0, 0, 32'h0);
      push_item(lsre_pkg::FUNC_WRITE, 0, 0, 0, 32'h0001_0000);
      push_item(lsre_pkg::FUNC_READ, 0, 0, 0, 32'h0);
      drain();

      // extreme settings, no sweep yet
      csr_write(lsre_pkg::CSR_PSEUDO_DT, 31'h7FFF_FFFF);
      csr_write(lsre_pkg::CSR_INV_X, 31'd0);
      csr_write(lsre_pkg::CSR_INV_Y, 31'h7FFF_FFFF);
      csr_write(lsre_pkg::CSR_INV_Z, 31'd0);
      csr_write(lsre_pkg::CSR_MIN_SP_SQ, 31'h7FFF_FFFF);
      csr_write(CSR_UNUSED, 31'h7FFF_FFFF);
      random_mix(150);
      drain();

      // fill the whole grid, then one sweep at moderate settings
      for (int z = 0; z < NZ; z++)
         for (int y = 0; y < NY; y++)
            for (int x = 0; x < NX; x++)
               push_item(lsre_pkg::FUNC_WRITE, x, y, z, some_distance());
      drain();
      csr_write(lsre_pkg::CSR_ITER_COUNT, 31'd1);
      csr_write(lsre_pkg::CSR_PSEUDO_DT, 31'($urandom_range(1, 65536)));
      csr_write(lsre_pkg::CSR_INV_X, 31'($urandom_range(32768, 131072)));
      csr_write(lsre_pkg::CSR_INV_Y, 31'($urandom_range(32768, 131072)));
      csr_write(lsre_pkg::CSR_INV_Z, 31'($urandom_range(32768, 131072)));
      csr_write(lsre_pkg::CSR_MIN_SP_SQ, 31'($urandom_range(0, 131072)));
      push_item(lsre_pkg::FUNC_RUN, 0, 0, 0, 32'h0);
      for (int i = 0; i < 60; i++) push_read();
      drain();

      // bulk random traffic with empty runs and a long receiver hold-off
      csr_write(lsre_pkg::CSR_ITER_COUNT, 31'h3FF);
      csr_write(lsre_pkg::CSR_ITER_COUNT, 31'd0);
      long_hold_go = 1'b1;
      random_mix(1500);
      drain();

      // one sweep at the saturating extremes
      csr_write(lsre_pkg::CSR_ITER_COUNT, 31'd1);
      csr_write(lsre_pkg::CSR_PSEUDO_DT, 31'h7FFF_FFFF);
      csr_write(lsre_pkg::CSR_INV_X, 31'h7FFF_FFFF);
      csr_write(lsre_pkg::CSR_INV_Y, 31'h7FFF_FFFF);
      csr_write(lsre_pkg::CSR_INV_Z, 31'h7FFF_FFFF);
      csr_write(lsre_pkg::CSR_MIN_SP_SQ, 31'd0);
      push_item(lsre_pkg::FUNC_RUN, 0, 0, 0, 32'h0);
      for (int i = 0; i < 60; i++) push_read();
      drain();

      // final stretch without stalls
      csr_write(lsre_pkg::CSR_ITER_COUNT, 31'd0);
      quiet = 1'b1;
      random_mix(200);
      drain();
      repeat (20) @(negedge clock);
      if (errors == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

   // watchdog
   initial begin
      #60ms;
      $display("end of test: mismatches");
      $finish;
   end
endmodule
`default_nettype wire
